FILE: hw/rtl/hsa_pkg.sv
// Shared constants and types of the HSL saturation adjust block.
package hsa_pkg;

  localparam int unsigned FracBits     = 16;
  localparam int unsigned NumCh        = 3;
  localparam logic [7:0]  NeutralLevel = 8'd80;
  localparam logic [8:0]  HalfSpan     = 9'd255;
  localparam logic [8:0]  FullSpan     = 9'd510;

  // Configuration register indexes.
  localparam logic CfgSatLevel = 1'b0;
  localparam logic CfgIncDiv   = 1'b1;

  // Channel byte and the pixel as a small array of channels.
  typedef logic [7:0] chan_t;
  typedef chan_t [NumCh-1:0] pixel_t;

endpackage

FILE: hw/rtl/hsa_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module hsa_div_pipe import hsa_pkg::*; #(
  parameter int DW = 24,
  parameter int VW = 8,
  parameter int PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [PW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] quot_o,
  output logic [PW-1:0] side_o
);

  logic [VW-1:0] rem_q  [DW];
  logic [DW-1:0] work_q [DW];
  logic [VW-1:0] dvs_q  [DW];
  logic [PW-1:0] side_q [DW];
  logic          valid_q [DW];

  for (genvar s = 0; s < DW; s++) begin : g_stage
    logic [VW-1:0] rem_in;
    logic [DW-1:0] work_in;
    logic [VW-1:0] dvs_in;
    logic [PW-1:0] side_in;
    logic          valid_in;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in   = '0;
      assign work_in  = dividend_i;
      assign dvs_in   = divisor_i;
      assign side_in  = side_i;
      assign valid_in = valid_i;
    end else begin : g_next
      assign rem_in   = rem_q[s-1];
      assign work_in  = work_q[s-1];
      assign dvs_in   = dvs_q[s-1];
      assign side_in  = side_q[s-1];
      assign valid_in = valid_q[s-1];
    end

    // Shift in the next dividend bit, subtract when it fits.
    assign trial = {rem_in, work_in[DW-1]};
    assign ge    = trial >= {1'b0, dvs_in};
    assign diff  = trial - {1'b0, dvs_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? diff[VW-1:0] : trial[VW-1:0];
        work_q[s] <= {work_in[DW-2:0], ge};
        dvs_q[s]  <= dvs_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[DW-1];
  assign quot_o  = work_q[DW-1];
  assign side_o  = side_q[DW-1];

endmodule

FILE: hw/rtl/hsl_saturation_adjust_top.sv
// Top level of the HSL saturation adjust pixel pipeline.
// Throughput: one pixel per cycle while no stall holds the output;
// the 24-stage and 33-stage divider pipelines set the depth.
// A stall of a valid result on the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and sets saturation_level to 80, increment_divisor to 200.
// Payload registers are not reset.
module hsl_saturation_adjust_top import hsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_wen_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o
);

  localparam int QW  = 24;           // quotient width of the first dividers
  localparam int AW  = FracBits + 1; // alpha width, Q1.16 up to one
  localparam int FW  = 2 * FracBits + 1;
  localparam int GW  = 26;           // signed negative-path gain
  localparam int MW  = FW + 2;       // signed multiplier operand
  localparam int KW  = 11;           // signed 2c - (max + min)
  localparam int PRW = KW + MW;
  localparam int SW1 = 1 + 9 + 8 * NumCh;
  localparam int SW2 = SW1 + 1 + GW;

  localparam logic [QW:0]   OneQ   = (QW+1)'(1) << FracBits;
  localparam logic [FW-1:0] OneSq  = FW'(1) << (2 * FracBits);

  // Configuration registers.
  logic [7:0] sat_level_q;
  logic [7:0] inc_div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_level_q <= 8'd80;
      inc_div_q   <= 8'd200;
    end else if (cfg_wen_i) begin
      unique case (cfg_idx_i)
        CfgSatLevel: sat_level_q <= cfg_data_i;
        CfgIncDiv:   inc_div_q   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Global advance: the whole pipe moves unless a finished result is stalled.
  logic en;
  assign en      = !valid_o || !stall_i;
  assign stall_o = !en;

  // ---------------- Stage 1: max, min, divider operands ----------------
  pixel_t     px_in;
  logic [7:0] mx, mn;
  logic [8:0] sum_d;
  logic [7:0] den_d, diff_d, incmag_d, div_d;
  logic       neg_d;

  assign px_in = {blue_in_i, green_in_i, red_in_i};

  always_comb begin
    mx = red_in_i;
    mn = red_in_i;
    for (int i = 1; i < NumCh; i++) begin
      if (px_in[i] > mx) mx = px_in[i];
      if (px_in[i] < mn) mn = px_in[i];
    end
    sum_d  = {1'b0, mx} + {1'b0, mn};
    diff_d = mx - mn;
    den_d  = (sum_d < HalfSpan) ? sum_d[7:0] : 8'(FullSpan - sum_d);
    neg_d  = sat_level_q < NeutralLevel;
    incmag_d = neg_d ? (NeutralLevel - sat_level_q) : (sat_level_q - NeutralLevel);
    div_d  = (inc_div_q == 8'd0) ? 8'd1 : inc_div_q;
  end

  logic       s1_valid_q;
  pixel_t     s1_px_q;
  logic [8:0] s1_sum_q;
  logic [7:0] s1_diff_q, s1_den_q, s1_incmag_q, s1_div_q;
  logic       s1_neg_q, s1_grey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_px_q     <= px_in;
      s1_sum_q    <= sum_d;
      s1_diff_q   <= diff_d;
      s1_den_q    <= den_d;
      s1_incmag_q <= incmag_d;
      s1_div_q    <= div_d;
      s1_neg_q    <= neg_d;
      s1_grey_q   <= (mx == mn);
    end
  end

  // ---------------- Dividers: saturation and increment ----------------
  logic           dv_sat_valid, dv_inc_valid;
  logic [QW-1:0]  q_sat, q_inc;
  logic [SW1-1:0] side1;
  logic           neg_p;

  hsa_div_pipe #(.DW(QW), .VW(8), .PW(SW1)) u_div_sat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s1_valid_q),
    .dividend_i ({s1_diff_q, FracBits'(0)}),
    .divisor_i  (s1_den_q),
    .side_i     ({s1_grey_q, s1_sum_q, s1_px_q}),
    .valid_o    (dv_sat_valid),
    .quot_o     (q_sat),
    .side_o     (side1)
  );

  hsa_div_pipe #(.DW(QW), .VW(8), .PW(1)) u_div_inc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s1_valid_q),
    .dividend_i ({s1_incmag_q, FracBits'(0)}),
    .divisor_i  (s1_div_q),
    .side_i     (s1_neg_q),
    .valid_o    (dv_inc_valid),
    .quot_o     (q_inc),
    .side_o     (neg_p)
  );

  // ---------------- Stage P: pick alpha and the negative gain ----------------
  logic [AW-1:0]  sat_p, alpha_d;
  logic           pos_d;
  logic [QW:0]    incsat;
  logic [GW-1:0]  g_d;

  always_comb begin
    sat_p  = q_sat[AW-1:0];
    // An increment truncated to zero takes the non-negative path.
    pos_d  = !neg_p || (q_inc == '0);
    incsat = {1'b0, q_inc} + (QW+1)'(sat_p);
    if (!pos_d) begin
      alpha_d = AW'(1);
    end else if (incsat >= OneQ) begin
      alpha_d = sat_p;
    end else begin
      alpha_d = AW'(OneQ - {1'b0, q_inc});
    end
    g_d = GW'(OneQ) - GW'(q_inc);
  end

  logic           sp_valid_q;
  logic [AW-1:0]  sp_alpha_q;
  logic [SW2-1:0] sp_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_valid_q <= 1'b0;
    end else if (en) begin
      sp_valid_q <= dv_sat_valid && dv_inc_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sp_alpha_q <= alpha_d;
      sp_side_q  <= {side1, pos_d, g_d};
    end
  end

  // ---------------- Divider: reciprocal of alpha ----------------
  logic           dv_f_valid;
  logic [FW-1:0]  q_f;
  logic [SW2-1:0] side2;

  hsa_div_pipe #(.DW(FW), .VW(AW), .PW(SW2)) u_div_f (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (sp_valid_q),
    .dividend_i (OneSq),
    .divisor_i  (sp_alpha_q),
    .side_i     (sp_side_q),
    .valid_o    (dv_f_valid),
    .quot_o     (q_f),
    .side_o     (side2)
  );

  logic                 m_grey;
  logic [8:0]           m_sum;
  pixel_t               m_px;
  logic                 m_pos;
  logic signed [GW-1:0] m_g;

  assign {m_grey, m_sum, m_px, m_pos, m_g} = side2;

  // ---------------- Stage M: one multiply per channel ----------------
  logic signed [MW-1:0]  f_s, mul_op;
  logic signed [KW-1:0]  k    [NumCh];
  logic signed [PRW-1:0] prod_d [NumCh];
  logic [24:0]           base_d [NumCh];

  always_comb begin
    f_s    = $signed({2'b00, q_f}) - $signed(MW'(OneQ));
    mul_op = m_pos ? f_s : MW'(m_g);
    for (int i = 0; i < NumCh; i++) begin
      k[i]      = $signed({2'b00, m_px[i], 1'b0}) - $signed({2'b00, m_sum});
      prod_d[i] = PRW'(k[i]) * PRW'(mul_op);
      base_d[i] = m_pos ? {1'b0, m_px[i], FracBits'(0)} : {1'b0, m_sum, (FracBits-1)'(0)};
    end
  end

  logic                  sm_valid_q;
  logic                  sm_grey_q;
  pixel_t                sm_px_q;
  logic signed [PRW-1:0] sm_prod_q [NumCh];
  logic [24:0]           sm_base_q [NumCh];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_valid_q <= 1'b0;
    end else if (en) begin
      sm_valid_q <= dv_f_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sm_grey_q <= m_grey;
      sm_px_q   <= m_px;
      for (int i = 0; i < NumCh; i++) begin
        sm_prod_q[i] <= prod_d[i];
        sm_base_q[i] <= base_d[i];
      end
    end
  end

  // ---------------- Output stage: add, truncate, clamp ----------------
  logic signed [PRW-1:0] psh [NumCh];
  logic [PRW:0]          res [NumCh];
  pixel_t                out_d;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      // Floor of the product over two, then add the base.
      psh[i] = sm_prod_q[i] >>> 1;
      res[i] = {psh[i][PRW-1], psh[i]} + (PRW+1)'(sm_base_q[i]);
      if (sm_grey_q) begin
        out_d[i] = sm_px_q[i];
      end else if (res[i][PRW]) begin
        out_d[i] = 8'd0;
      end else if (|res[i][PRW-1:24]) begin
        out_d[i] = 8'd255;
      end else begin
        out_d[i] = res[i][23:16];
      end
    end
  end

  pixel_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= sm_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign red_out_o   = out_q[0];
  assign green_out_o = out_q[1];
  assign blue_out_o  = out_q[2];

  // ---------------- Assertions ----------------
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_grey_q |-> s1_den_q != 8'd0)
    else $error("saturation divisor is zero for a colored pixel");

  // The grey flag is the top bit of the sideband; grey pixels ignore alpha.
  a_alpha_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_valid_q && !sp_side_q[SW2-1] |-> sp_alpha_q != '0)
    else $error("alpha is zero");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(s1_valid_q) && $stable(sm_valid_q))
    else $error("pipeline moved while stalled");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> valid_o == $past(sm_valid_q))
    else $error("output valid lost or invented");

  a_div_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_sat_valid == dv_inc_valid)
    else $error("parallel dividers out of step");

endmodule

FILE: dv/hsl_saturation_adjust_top_tb.sv
// Self-checking testbench of the HSL saturation adjust pixel pipeline.
`timescale 1ns / 100ps

module hsl_saturation_adjust_top_tb import hsa_pkg::*;;

  localparam int  PipeLatency  = 60;
  localparam int  HoldCycles   = 400;
  localparam int  IdleLimit    = 3000;
  localparam longint OneQ      = 64'sd65536;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       cfg_wen_i  = 1'b0;
  logic       cfg_idx_i  = 1'b0;
  logic [7:0] cfg_data_i = 8'd0;
  logic       valid_i    = 1'b0;
  logic       stall_o;
  logic [7:0] red_in_i   = 8'd0;
  logic [7:0] green_in_i = 8'd0;
  logic [7:0] blue_in_i  = 8'd0;
  logic       valid_o;
  logic       stall_i    = 1'b0;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;

  hsl_saturation_adjust_top u_dut (
    .clk_i, .rst_ni, .cfg_wen_i, .cfg_idx_i, .cfg_data_i,
    .valid_i, .stall_o, .red_in_i, .green_in_i, .blue_in_i,
    .valid_o, .stall_i, .red_out_o, .green_out_o, .blue_out_o
  );

  // 20 ns clock: high and low halves.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the configuration registers, updated with each write.
  chan_t   sat_level_q = 8'd80;
  chan_t   inc_div_q   = 8'd200;

  pixel_t  pixels_to_send[$];
  pixel_t  adjusted_pixels[$];
  int      mismatch_cnt = 0;
  int      idle_cycles  = 0;
  bit      hold_request = 1'b0;

  // Floor of x / 2^16 for signed x.
  function automatic longint floor_frac(longint x);
    if (x >= 0) return x / OneQ;
    return -((-x + OneQ - 1) / OneQ);
  endfunction

  function automatic chan_t clamp_byte(longint v);
    longint t;
    if (v < 0) return 8'd0;
    t = v / OneQ;
    return (t > 255) ? 8'd255 : chan_t'(t);
  endfunction

  // Expected output pixel for one input pixel under the current settings.
  function automatic pixel_t adjust_saturation(pixel_t px);
    longint ch[NumCh];
    longint mx, mn, den, sat, inc, lum, dv, alpha, fac, c;
    pixel_t res;
    for (int i = 0; i < NumCh; i++) ch[i] = longint'(px[i]);
    mx = ch[0];
    mn = ch[0];
    for (int i = 1; i < NumCh; i++) begin
      if (ch[i] > mx) mx = ch[i];
      if (ch[i] < mn) mn = ch[i];
    end
    // Grey pixels pass through untouched.
    if (mx == mn) return px;
    dv = longint'(inc_div_q);
    if (dv == 0) dv = 1;
    inc = ((longint'(sat_level_q) - longint'(NeutralLevel)) * OneQ) / dv;
    den = (mx + mn < 255) ? (mx + mn) : (510 - mx - mn);
    sat = ((mx - mn) * OneQ) / den;
    lum = (mx + mn) * (OneQ / 2);
    if (inc >= 0) begin
      alpha = (inc + sat >= OneQ) ? sat : (OneQ - inc);
      fac = (OneQ * OneQ) / alpha - OneQ;
      for (int i = 0; i < NumCh; i++) begin
        c = ch[i] * OneQ;
        res[i] = clamp_byte(c + floor_frac((c - lum) * fac));
      end
    end else begin
      // A factor below zero mirrors channels through lightness.
      fac = OneQ + inc;
      for (int i = 0; i < NumCh; i++) begin
        c = ch[i] * OneQ;
        res[i] = clamp_byte(lum + floor_frac((c - lum) * fac));
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, chan_t got, chan_t want);
    $display("%0t: %s got %0d expected %0d", $time, field, got, want);
    mismatch_cnt++;
  endtask

  // Driver: offer pending pixels in bursts separated by random gaps. Valid
  // changes only while stall_o is low or nothing is offered; a stalled payload is held.
  int burst_left = 1;
  int gap_left   = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t px;
    if (!rst_ni) begin
      valid_i <= 1'b0;
    end else begin
      if (valid_i && !stall_o)
        adjusted_pixels = {adjusted_pixels,
                           adjust_saturation({blue_in_i, green_in_i, red_in_i})};
      if (!valid_i || !stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          valid_i <= 1'b0;
        end else if (pixels_to_send.size() > 0) begin
          px = pixels_to_send.pop_front();
          red_in_i   <= px[0];
          green_in_i <= px[1];
          blue_in_i  <= px[2];
          valid_i    <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            // Mostly no gap, sometimes short, now and then long.
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(1, 3);
              2: gap_left = $urandom_range(1, 12);
              default: gap_left = 0;
            endcase
          end
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction and drive the stall pattern.
  int stall_pct  = 0;
  int pat_left   = 0;
  int hold_left  = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      stall_i <= 1'b0;
    end else begin
      if (valid_o && !stall_i) begin
        if (adjusted_pixels.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $time);
          mismatch_cnt++;
        end else begin
          want = adjusted_pixels.pop_front();
          if (red_out_o   !== want[0]) report_mismatch("red",   red_out_o,   want[0]);
          if (green_out_o !== want[1]) report_mismatch("green", green_out_o, want[1]);
          if (blue_out_o  !== want[2]) report_mismatch("blue",  blue_out_o,  want[2]);
        end
      end
      // Long hold-off fills the pipeline so the input side must stall.
      if (hold_request && hold_left == 0) begin
        hold_request <= 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_i <= 1'b1;
      end else begin
        if (pat_left <= 0) begin
          pat_left = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        pat_left--;
        stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Watchdog: count cycles without any transaction on either side.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic idx, chan_t val);
    @(posedge clk_i);
    cfg_wen_i  <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_wen_i  <= 1'b0;
    if (idx == CfgSatLevel) sat_level_q = val;
    else inc_div_q = val;
  endtask

  // Wait for the pipeline to drain, then let it settle before a write.
  task automatic drain_pipe();
    while (pixels_to_send.size() > 0 || valid_i || adjusted_pixels.size() > 0)
      @(posedge clk_i);
    repeat (PipeLatency + 8) @(posedge clk_i);
  endtask

  task automatic queue_pixel(chan_t r, chan_t g, chan_t b);
    pixels_to_send = {pixels_to_send, pixel_t'({b, g, r})};
  endtask

  task automatic queue_random(int n);
    chan_t r, g, b, base;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: begin                       // grey
          r = chan_t'($urandom); g = r; b = r;
        end
        1, 2: begin                    // near grey
          base = chan_t'($urandom_range(2, 253));
          r = chan_t'(base + $urandom_range(0, 2) - 1);
          g = chan_t'(base + $urandom_range(0, 2) - 1);
          b = base;
        end
        3: begin                       // saturated extremes
          r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          g = $urandom_range(0, 1) ? 8'd255 : chan_t'($urandom);
          b = $urandom_range(0, 1) ? 8'd0 : chan_t'($urandom);
        end
        default: begin
          r = chan_t'($urandom); g = chan_t'($urandom); b = chan_t'($urandom);
        end
      endcase
      queue_pixel(r, g, b);
    end
  endtask

  task automatic queue_directed();
    queue_pixel(8'd0,   8'd0,   8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd128, 8'd128, 8'd128);
    queue_pixel(8'd255, 8'd0,   8'd0);
    queue_pixel(8'd0,   8'd255, 8'd0);
    queue_pixel(8'd0,   8'd0,   8'd255);
    queue_pixel(8'd1,   8'd0,   8'd0);
    queue_pixel(8'd255, 8'd254, 8'd254);
    queue_pixel(8'd127, 8'd128, 8'd0);
    queue_pixel(8'd128, 8'd127, 8'd255);
    queue_pixel(8'd200, 8'd100, 8'd50);
    queue_pixel(8'd10,  8'd20,  8'd30);
    queue_pixel(8'd170, 8'd85,  8'd85);
    queue_pixel(8'd254, 8'd1,   8'd128);
  endtask

  // Settings per phase: saturation level and divisor, extremes included.
  // A zero divisor counts as one; level 0 with divisor 1 drives the
  // factor far below zero.
  chan_t phase_sat[9] = '{8'd80, 8'd255, 8'd0,   8'd255, 8'd0,   8'd81, 8'd79, 8'd160, 8'd0};
  chan_t phase_div[9] = '{8'd200, 8'd1,  8'd1,   8'd255, 8'd255, 8'd200, 8'd0, 8'd50, 8'd0};

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < 12; p++) begin
      if (p > 0) begin
        drain_pipe();
        if (p < 9) begin
          write_reg(CfgSatLevel, phase_sat[p]);
          write_reg(CfgIncDiv,   phase_div[p]);
        end else begin
          write_reg(CfgSatLevel, chan_t'($urandom));
          write_reg(CfgIncDiv,   chan_t'($urandom_range(0, 255)));
        end
      end
      @(negedge clk_i);
      if (p < 3 || p == 6) queue_directed();
      queue_random(85);
      // Ask for one long receiver hold-off while the sender keeps going.
      if (p == 4) hold_request = 1'b1;
    end
    while (pixels_to_send.size() > 0 || valid_i || adjusted_pixels.size() > 0)
      @(posedge clk_i);
    repeat (PipeLatency + 8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
